// File: hw/rtl/swmmm_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the sliding window min/max/mean block.
// No dependencies; imported by every module under hw/rtl.
package swmmm_pkg;

    localparam int DATA_W    = 32;
    // reciprocal of WINDOW is scaled by 2^(clog2(WINDOW) + RECIP_SH)
    localparam int RECIP_SH  = DATA_W - 1;
    // reciprocal estimate is at most this many below the true quotient
    localparam int FIX_STEPS = 4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_MUL_RECIP,
        ST_MUL_BACK,
        ST_SUB,
        ST_FIX,
        ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_CLEAR,
        OP_ACCUM,
        OP_MUL_RECIP,
        OP_MUL_BACK,
        OP_SUB,
        OP_FIX
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   wr_en;
        logic   rd_en;
        logic   load_out;
    } ctrl_t;

endpackage

// File: hw/rtl/swmmm_ring.sv
`timescale 1ns / 1ps
// Sample ring: WINDOW x 32 memory with one write and one registered read port.
// Depends on swmmm_pkg. Slots never written read back as zero (fill tracking).
module swmmm_ring #(
    parameter int WINDOW = 100
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  swmmm_pkg::ctrl_t                    ctrl,
    input  logic [swmmm_pkg::DATA_W-1:0]        wr_data,
    input  logic [$clog2(WINDOW)-1:0]           rd_addr,
    output logic [swmmm_pkg::DATA_W-1:0]        rd_data
);
    import swmmm_pkg::*;

    localparam int IDX_W = $clog2(WINDOW);

    logic [DATA_W-1:0] mem [WINDOW];
    logic [DATA_W-1:0] rd_data_reg;
    logic              rd_live_reg;
    logic [IDX_W-1:0]  slot_reg, slot_next;
    logic              full_reg, full_next;

    // Slots fill in order from zero, so slot/full tell which ones hold data.
    always_comb begin
        slot_next = slot_reg;
        full_next = full_reg;
        if (ctrl.wr_en) begin
            if (slot_reg == IDX_W'(WINDOW - 1)) begin
                slot_next = '0;
                full_next = 1'b1;
            end else begin
                slot_next = slot_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg <= '0;
            full_reg <= 1'b0;
        end else begin
            slot_reg <= slot_next;
            full_reg <= full_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.wr_en) begin
            mem[slot_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.rd_en) begin
            rd_data_reg <= mem[rd_addr];
            rd_live_reg <= full_reg || (rd_addr < slot_reg);
        end
    end

    assign rd_data = rd_live_reg ? rd_data_reg : '0;

endmodule

// File: hw/rtl/swmmm_datapath.sv
`timescale 1ns / 1ps
// Shared datapath: min/max tracking, one adder for the running sum, remainder and
// correction steps, and one 32x32 multiplier for the reciprocal divide by WINDOW.
// Depends on swmmm_pkg.
module swmmm_datapath #(
    parameter int WINDOW = 100
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  swmmm_pkg::ctrl_t                    ctrl,
    input  logic [swmmm_pkg::DATA_W-1:0]        rd_data,
    output logic [swmmm_pkg::DATA_W-1:0]        min_val,
    output logic [swmmm_pkg::DATA_W-1:0]        max_val,
    output logic [swmmm_pkg::DATA_W-1:0]        mean_val
);
    import swmmm_pkg::*;

    localparam int IDX_W  = $clog2(WINDOW);
    localparam int SUM_W  = DATA_W + IDX_W;
    localparam int ADD_W  = SUM_W + 1;
    localparam int REM_W  = IDX_W + 3;
    localparam int PROD_W = 2 * DATA_W;
    // floor(2^(IDX_W + RECIP_SH) / WINDOW); fits DATA_W bits since WINDOW > 2^(IDX_W-1)
    localparam logic [63:0]       RECIP_WIDE = (64'd1 << (IDX_W + RECIP_SH)) / 64'(WINDOW);
    localparam logic [DATA_W-1:0] RECIP      = RECIP_WIDE[DATA_W-1:0];

    logic [DATA_W-1:0] min_reg, min_next;
    logic [DATA_W-1:0] max_reg, max_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [DATA_W-1:0] q_reg, q_next;        // quotient estimate, then exact mean
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [REM_W-1:0]  rem_reg, rem_next;    // below 5 * WINDOW after the subtract

    logic [ADD_W-1:0]  add_a, add_b, add_res;
    logic              add_cin;
    logic              fix_ge;
    logic [DATA_W-1:0] mul_a, mul_b;
    logic [PROD_W-1:0] mul_res;

    // Top DATA_W bits of the sum times the reciprocal, then estimate times WINDOW.
    always_comb begin
        mul_a = sum_reg[SUM_W-1 -: DATA_W];
        mul_b = RECIP;
        if (ctrl.op == OP_MUL_BACK) begin
            mul_a = prod_reg[RECIP_SH +: DATA_W];
            mul_b = DATA_W'(WINDOW);
        end
    end

    assign mul_res = PROD_W'(mul_a) * PROD_W'(mul_b);

    always_comb begin
        add_a   = {1'b0, sum_reg};
        add_b   = ADD_W'(rd_data);
        add_cin = 1'b0;
        case (ctrl.op)
            OP_SUB: begin
                add_b   = ~{1'b0, prod_reg[SUM_W-1:0]};
                add_cin = 1'b1;
            end
            OP_FIX: begin
                add_a   = ADD_W'(rem_reg);
                add_b   = ~ADD_W'(WINDOW);
                add_cin = 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign add_res = add_a + add_b + ADD_W'(add_cin);
    assign fix_ge  = !add_res[ADD_W-1];

    always_comb begin
        min_next  = min_reg;
        max_next  = max_reg;
        sum_next  = sum_reg;
        q_next    = q_reg;
        prod_next = prod_reg;
        rem_next  = rem_reg;
        case (ctrl.op)
            OP_CLEAR: begin
                min_next = '1;
                max_next = '0;
                sum_next = '0;
            end
            OP_ACCUM: begin
                if (rd_data < min_reg) begin
                    min_next = rd_data;
                end
                if (rd_data > max_reg) begin
                    max_next = rd_data;
                end
                sum_next = add_res[SUM_W-1:0];
            end
            OP_MUL_RECIP: begin
                prod_next = mul_res;
            end
            OP_MUL_BACK: begin
                q_next    = prod_reg[RECIP_SH +: DATA_W];
                prod_next = mul_res;
            end
            OP_SUB: begin
                rem_next = add_res[REM_W-1:0];
            end
            OP_FIX: begin
                // estimate runs low by up to FIX_STEPS; step it up while rem >= WINDOW
                if (fix_ge) begin
                    rem_next = add_res[REM_W-1:0];
                    q_next   = q_reg + 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        min_reg  <= min_next;
        max_reg  <= max_next;
        sum_reg  <= sum_next;
        q_reg    <= q_next;
        prod_reg <= prod_next;
        rem_reg  <= rem_next;
    end

    assign min_val  = min_reg;
    assign max_val  = max_reg;
    assign mean_val = q_reg;

    a_minmax_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.op == OP_ACCUM) |=> (min_reg <= max_reg))
        else $error("min above max after accumulate");

    a_rem_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.load_out |-> (rem_reg < REM_W'(WINDOW)))
        else $error("divide remainder out of range");

    a_clear_init: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.op == OP_CLEAR) |=> (sum_reg == '0 && max_reg == '0 && min_reg == '1))
        else $error("clear did not initialize accumulators");

endmodule

// File: hw/rtl/swmmm_ctrl.sv
`timescale 1ns / 1ps
// Sequencer: accept, ring scan, reciprocal divide steps, result hand-off.
// Depends on swmmm_pkg.
module swmmm_ctrl #(
    parameter int WINDOW = 100
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        m_valid,
    input  logic                        m_ready,
    output swmmm_pkg::ctrl_t            ctrl,
    output logic [$clog2(WINDOW)-1:0]   rd_addr
);
    import swmmm_pkg::*;

    localparam int IDX_W = $clog2(WINDOW);
    localparam int FIX_W = $clog2(FIX_STEPS);
    localparam int CNT_W = (IDX_W > FIX_W) ? IDX_W : FIX_W;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             scan_last;
    logic             fix_last;

    assign scan_last = (cnt_reg == CNT_W'(WINDOW - 1));
    assign fix_last  = (cnt_reg == CNT_W'(FIX_STEPS - 1));
    assign rd_addr   = cnt_reg[IDX_W-1:0];

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:      if (s_valid) state_next = ST_SCAN;
            ST_SCAN:      if (scan_last) state_next = ST_DRAIN;
            ST_DRAIN:     state_next = ST_MUL_RECIP;
            ST_MUL_RECIP: state_next = ST_MUL_BACK;
            ST_MUL_BACK:  state_next = ST_SUB;
            ST_SUB:       state_next = ST_FIX;
            ST_FIX:       if (fix_last) state_next = ST_DONE;
            ST_DONE:      if (!m_valid || m_ready) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        s_ready       = 1'b0;
        ctrl.op       = OP_HOLD;
        ctrl.wr_en    = 1'b0;
        ctrl.rd_en    = 1'b0;
        ctrl.load_out = 1'b0;
        cnt_next      = '0;
        unique case (state_reg)
            ST_IDLE: begin
                // nothing is taken while reset is held
                s_ready    = aresetn;
                ctrl.wr_en = s_valid && aresetn;
                ctrl.op    = (s_valid && aresetn) ? OP_CLEAR : OP_HOLD;
            end
            ST_SCAN: begin
                ctrl.rd_en = 1'b1;
                // read data is registered, so it arrives in the cycle after its address
                ctrl.op    = (cnt_reg != '0) ? OP_ACCUM : OP_HOLD;
                cnt_next   = scan_last ? '0 : cnt_reg + 1'b1;
            end
            ST_DRAIN: begin
                ctrl.op = OP_ACCUM;
            end
            ST_MUL_RECIP: begin
                ctrl.op = OP_MUL_RECIP;
            end
            ST_MUL_BACK: begin
                ctrl.op = OP_MUL_BACK;
            end
            ST_SUB: begin
                ctrl.op = OP_SUB;
            end
            ST_FIX: begin
                ctrl.op  = OP_FIX;
                cnt_next = fix_last ? '0 : cnt_reg + 1'b1;
            end
            ST_DONE: begin
                ctrl.load_out = !m_valid || m_ready;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    a_accept_to_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_SCAN && cnt_reg == '0))
        else $error("accepted transaction did not start a scan at slot zero");

    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (cnt_reg <= CNT_W'(WINDOW - 1)))
        else $error("scan index past ring end");

    a_drain_to_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DRAIN) |=> (state_reg == ST_MUL_RECIP))
        else $error("drain did not hand off to divide");

    a_div_to_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FIX && fix_last) |=> (state_reg == ST_DONE))
        else $error("divide did not finish into result hand-off");

endmodule

// File: hw/rtl/sliding_window_min_max_mean.sv
`timescale 1ns / 1ps
// Top level: sliding window min/max/mean over Q16.16 timing samples.
// Depends on swmmm_pkg, swmmm_ring, swmmm_datapath, swmmm_ctrl.
//
//  channel | ports                                       | moves
//  --------+---------------------------------------------+---------------------------
//  input   | s_valid, s_ready, s_sample                  | one sample per transaction
//  result  | m_valid, m_ready, m_window_{min,max,mean}   | one result per sample
//
// Steps: each sample passes one accept step, WINDOW scan reads plus one drain
//   accumulate (one read port sets these), two multiplies and a subtract for the
//   reciprocal divide, FIX_STEPS = 4 correction steps and one hand-off.
// Reset: aresetn low clears the sequencer, fill tracking and result valid and holds
//   s_ready low; ring slots never written read as zero, so no clearing pass is needed.
// Stalls: s_ready is high only while idle. A finished result waits in the output
//   register; the next sample is taken meanwhile, and its result waits for m_ready.
module sliding_window_min_max_mean #(
    parameter int WINDOW = 100
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [swmmm_pkg::DATA_W-1:0]    s_sample,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [swmmm_pkg::DATA_W-1:0]    m_window_min,
    output logic [swmmm_pkg::DATA_W-1:0]    m_window_max,
    output logic [swmmm_pkg::DATA_W-1:0]    m_window_mean
);
    import swmmm_pkg::*;

    localparam int IDX_W = $clog2(WINDOW);

    ctrl_t             ctrl;
    logic [IDX_W-1:0]  rd_addr;
    logic [DATA_W-1:0] rd_data;
    logic [DATA_W-1:0] min_val, max_val, mean_val;

    logic              m_valid_reg, m_valid_next;
    logic [DATA_W-1:0] min_out_reg, max_out_reg, mean_out_reg;

    // Sequencer: walks accept -> scan -> drain -> divide -> hand-off.
    swmmm_ctrl #(
        .WINDOW (WINDOW)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid_reg),
        .m_ready (m_ready),
        .ctrl    (ctrl),
        .rd_addr (rd_addr)
    );

    // Ring memory; the new sample is written in the accept cycle, so the scan
    // that follows already sees it.
    swmmm_ring #(
        .WINDOW (WINDOW)
    ) u_ring (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ctrl),
        .wr_data (s_sample),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Min/max compare, the shared adder and the reciprocal multiplier.
    swmmm_datapath #(
        .WINDOW (WINDOW)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (ctrl),
        .rd_data  (rd_data),
        .min_val  (min_val),
        .max_val  (max_val),
        .mean_val (mean_val)
    );

    // Output register: load only when empty or being drained this cycle.
    always_comb begin
        m_valid_next = m_valid_reg;
        if (ctrl.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load_out) begin
            min_out_reg  <= min_val;
            max_out_reg  <= max_val;
            mean_out_reg <= mean_val;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_window_min  = min_out_reg;
    assign m_window_max  = max_out_reg;
    assign m_window_mean = mean_out_reg;

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.load_out |-> (!m_valid_reg || m_ready))
        else $error("result register loaded over a pending transaction");

    a_load_sets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.load_out |=> m_valid_reg)
        else $error("loaded result not presented");

    a_mean_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.load_out |-> (mean_val <= max_val && mean_val >= min_val))
        else $error("mean outside min/max range");

endmodule
